// File: src/linked_fifo_with_free_list_core_defines.svh
// Assertion macros for the linked FIFO core.
// Used by files that hold concurrent checks; expects clock and reset in scope.
`ifndef LINKED_FIFO_WITH_FREE_LIST_CORE_DEFINES_SVH
`define LINKED_FIFO_WITH_FREE_LIST_CORE_DEFINES_SVH

// same-cycle implication
`define LFFL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lffl_pkg.sv
// Shared constants and types for the linked FIFO core.
// No dependencies.
`timescale 1ns / 1ps

package lffl_pkg;

   localparam int CAPACITY = 15;
   localparam int DATA_W   = 64;
   localparam int NODES    = CAPACITY + 1;
   localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 64;
   localparam int OCC_W    = 4;

   typedef logic [NODE_W-1:0] node_idx_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } fsm_state_type;

endpackage

// File: src/linked_fifo_with_free_list_core.sv
// Linked-list FIFO core: node pool with a data memory and a link memory.
// Depends on lffl_pkg and linked_fifo_with_free_list_core_defines.svh.
`timescale 1ns / 1ps
`include "linked_fifo_with_free_list_core_defines.svh"

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// request   req_mode, req_write_value               start high while busy low
// response  rsp_success, rsp_read_value,            rsp_strobe, one cycle,
//           rsp_occupancy                           no backpressure
//
// In each transaction the accept edge issues the memory reads
// (free link at free head, queue link and data at the front node), the next
// cycle modifies and writes back and shows the response with rsp_strobe.
// busy is high in that cycle, so accesses never overlap.
// Synchronous reset leaves an empty queue with node 0 as sentinel; no
// clearing pass (free links default through per-node valid flops).

module linked_fifo_with_free_list_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [lffl_pkg::VALUE_W-1:0] req_write_value,
   output logic                        rsp_strobe,
   output logic                        rsp_success,
   output logic [lffl_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [lffl_pkg::OCC_W-1:0]   rsp_occupancy
);

   // memories
   logic [lffl_pkg::DATA_W-1:0] node_mem  [lffl_pkg::NODES];
   // one link per node: queue link while queued, free link while spare
   lffl_pkg::node_idx_type      link_mem  [lffl_pkg::NODES];
   logic [lffl_pkg::NODES-1:0]  flink_vld_ff;

   // control state
   lffl_pkg::fsm_state_type state_ff, state_in;
   lffl_pkg::node_idx_type  free_head_ff, free_head_in;
   lffl_pkg::node_idx_type  queue_head_ff, queue_head_in;
   lffl_pkg::node_idx_type  queue_tail_ff, queue_tail_in;
   lffl_pkg::node_idx_type  head_next_ff, head_next_in;   // front data node
   lffl_pkg::count_type     entry_count_ff, entry_count_in;

   // captured request and read data
   lffl_pkg::mode_type          mode_ff;
   logic [lffl_pkg::DATA_W-1:0] value_ff;
   logic [lffl_pkg::DATA_W-1:0] node_rd_ff;
   lffl_pkg::node_idx_type      qlink_rd_ff;
   lffl_pkg::node_idx_type      flink_rd_ff;
   logic                        flink_vld_rd_ff;

   logic accept;
   logic exec;
   logic wr_ok;
   logic rd_ok;
   lffl_pkg::node_idx_type free_next;

   assign accept = start && !busy;
   assign exec   = (state_ff == lffl_pkg::ST_EXEC);
   assign wr_ok  = exec && (mode_ff == lffl_pkg::MODE_WRITE) &&
                   (entry_count_ff != lffl_pkg::CNT_W'(lffl_pkg::CAPACITY));
   assign rd_ok  = exec && (mode_ff == lffl_pkg::MODE_READ) && (entry_count_ff != '0);

   // unwritten free link defaults to the next node
   assign free_next = flink_vld_rd_ff ? flink_rd_ff :
                      lffl_pkg::NODE_W'(32'(free_head_ff) + 32'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lffl_pkg::ST_IDLE: if (start) state_in = lffl_pkg::ST_EXEC;
         lffl_pkg::ST_EXEC: state_in = lffl_pkg::ST_IDLE;
         default:           state_in = lffl_pkg::ST_IDLE;
      endcase
   end

   // list update
   always_comb begin
      free_head_in   = free_head_ff;
      queue_head_in  = queue_head_ff;
      queue_tail_in  = queue_tail_ff;
      head_next_in   = head_next_ff;
      entry_count_in = entry_count_ff;
      if (wr_ok) begin
         free_head_in   = free_next;
         queue_tail_in  = free_head_ff;
         if (entry_count_ff == '0) head_next_in = free_head_ff;
         entry_count_in = entry_count_ff + lffl_pkg::CNT_W'(1);
      end else if (rd_ok) begin
         // front node becomes sentinel, old sentinel heads the free list
         queue_head_in  = head_next_ff;
         head_next_in   = qlink_rd_ff;
         free_head_in   = queue_head_ff;
         entry_count_in = entry_count_ff - lffl_pkg::CNT_W'(1);
      end
   end

   // outputs
   always_comb begin
      busy           = exec;
      rsp_strobe     = exec;
      rsp_success    = wr_ok || rd_ok;
      rsp_read_value = rd_ok ? lffl_pkg::VALUE_W'(node_rd_ff) : '0;
      rsp_occupancy  = lffl_pkg::OCC_W'(entry_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lffl_pkg::ST_IDLE;
         free_head_ff   <= lffl_pkg::NODE_W'(1);
         queue_head_ff  <= '0;
         queue_tail_ff  <= '0;
         entry_count_ff <= '0;
         flink_vld_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         queue_head_ff  <= queue_head_in;
         queue_tail_ff  <= queue_tail_in;
         entry_count_ff <= entry_count_in;
         if (rd_ok) flink_vld_ff[queue_head_ff] <= 1'b1;
      end
   end

   // request capture and registered memory reads
   always_ff @(posedge clock) begin
      head_next_ff <= head_next_in;
      if (accept) begin
         mode_ff         <= lffl_pkg::mode_type'(req_mode);
         value_ff        <= req_write_value[lffl_pkg::DATA_W-1:0];
         node_rd_ff      <= node_mem[head_next_ff];
         qlink_rd_ff     <= link_mem[head_next_ff];
         flink_rd_ff     <= link_mem[free_head_ff];
         flink_vld_rd_ff <= flink_vld_ff[free_head_ff];
      end
   end

   // memory write-back
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         node_mem[free_head_ff]  <= value_ff;
         link_mem[queue_tail_ff] <= free_head_ff;
      end else if (rd_ok) begin
         link_mem[queue_head_ff] <= free_head_ff;
      end
   end

   `LFFL_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_strobe, "accepted transaction gave no response")
   `LFFL_ASSERT_NOW(a_count_bound, 1'b1, 32'(entry_count_ff) <= lffl_pkg::CAPACITY, "entry count above capacity")
   `LFFL_ASSERT_NOW(a_empty_head_tail, entry_count_ff == '0, queue_head_ff == queue_tail_ff, "empty queue with head unlike tail")
   `LFFL_ASSERT_NEXT(a_read_decrements, rd_ok, entry_count_ff == $past(entry_count_ff) - lffl_pkg::CNT_W'(1), "read did not decrement count")

endmodule

// File: tb/linked_fifo_with_free_list_core_tb.sv
// Self-checking testbench for linked_fifo_with_free_list_core: node-pool predictor
// in a scoreboard class, randomized write/read traffic with idle gaps.
// Depends on lffl_pkg and the core RTL.
`timescale 1ns / 1ps

module linked_fifo_with_free_list_core_tb;

   localparam int RANDOM_ITEMS = 1580;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 31;
   localparam int DRAIN_CYCLES = 6;

   typedef struct {
      logic                         success;
      logic [lffl_pkg::VALUE_W-1:0] word;
      logic [lffl_pkg::OCC_W-1:0]   occ;
   } fifo_rsp_type;

   // Mirror of the node pool: chain behind a sentinel plus a free list.
   class fifo_scoreboard_type;
      logic [lffl_pkg::VALUE_W-1:0] node_word [lffl_pkg::NODES];
      lffl_pkg::node_idx_type       chain_next [lffl_pkg::NODES];
      bit                           chain_ok [lffl_pkg::NODES];
      lffl_pkg::node_idx_type       spare_next [lffl_pkg::NODES];
      bit                           spare_ok [lffl_pkg::NODES];
      lffl_pkg::node_idx_type       spare_head;
      bit                           spare_head_ok;
      lffl_pkg::node_idx_type       front;
      lffl_pkg::node_idx_type       back;
      int unsigned                  depth;
      fifo_rsp_type                 due_responses [$];
      int                           errors;
      int                           writes_done;
      int                           reads_done;
      int                           writes_refused;
      int                           reads_refused;

      function new();
         for (int i = 0; i < lffl_pkg::NODES; i++) begin
            node_word[i]  = '0;
            chain_next[i] = '0;
            chain_ok[i]   = 1'b0;
            spare_next[i] = lffl_pkg::node_idx_type'((i + 1) % lffl_pkg::NODES);
            spare_ok[i]   = (i + 1 < lffl_pkg::NODES);
         end
         // node 0 starts as the sentinel
         spare_head    = lffl_pkg::node_idx_type'(1);
         spare_head_ok = 1'b1;
         front         = '0;
         back          = '0;
         depth         = 0;
         errors        = 0;
         writes_done   = 0;
         reads_done    = 0;
         writes_refused = 0;
         reads_refused  = 0;
      endfunction

      function void log_request(lffl_pkg::mode_type op,
                                logic [lffl_pkg::VALUE_W-1:0] value);
         fifo_rsp_type           r;
         lffl_pkg::node_idx_type n;
         lffl_pkg::node_idx_type old;
         r.success = 1'b0;
         r.word    = '0;
         if (op == lffl_pkg::MODE_WRITE) begin
            if (spare_head_ok) begin
               n             = spare_head;
               spare_head    = spare_next[n];
               spare_head_ok = spare_ok[n];
               node_word[n]  = value;
               chain_ok[n]   = 1'b0;
               chain_next[back] = n;
               chain_ok[back]   = 1'b1;
               back          = n;
               depth++;
               r.success     = 1'b1;
               writes_done++;
            end else begin
               writes_refused++;
            end
         end else begin
            if (front != back && chain_ok[front]) begin
               old             = front;
               front           = chain_next[old];
               r.word          = node_word[front];
               chain_ok[old]   = 1'b0;
               // retired sentinel goes to the front of the free list
               spare_next[old] = spare_head;
               spare_ok[old]   = spare_head_ok;
               spare_head      = old;
               spare_head_ok   = 1'b1;
               if (depth > 0) depth--;
               r.success       = 1'b1;
               reads_done++;
            end else begin
               reads_refused++;
            end
         end
         r.occ = lffl_pkg::OCC_W'(depth);
         due_responses.push_back(r);
      endfunction

      function void check_response(logic success, logic [lffl_pkg::VALUE_W-1:0] word,
                                   logic [lffl_pkg::OCC_W-1:0] occ);
         fifo_rsp_type e;
         if (due_responses.size() == 0) begin
            $display("%0t: response with none outstanding: success=%0b word=%h occ=%0d",
                     $time, success, word, occ);
            errors++;
            return;
         end
         e = due_responses.pop_front();
         if (success !== e.success) begin
            $display("%0t: rsp_success expected %0b actual %0b", $time, e.success, success);
            errors++;
         end
         if (word !== e.word) begin
            $display("%0t: rsp_read_value expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (occ !== e.occ) begin
            $display("%0t: rsp_occupancy expected %0d actual %0d", $time, e.occ, occ);
            errors++;
         end
      endfunction

      function int pending();
         return due_responses.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_mode;
   logic [lffl_pkg::VALUE_W-1:0]  req_write_value;
   logic                          rsp_strobe;
   logic                          rsp_success;
   logic [lffl_pkg::VALUE_W-1:0]  rsp_read_value;
   logic [lffl_pkg::OCC_W-1:0]    rsp_occupancy;

   fifo_scoreboard_type sb = new();
   int unsigned         cycle_count = 0;

   linked_fifo_with_free_list_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_write_value (req_write_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_success     (rsp_success),
      .rsp_read_value  (rsp_read_value),
      .rsp_occupancy   (rsp_occupancy)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Response first: a strobe always belongs to an earlier transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_success, rsp_read_value, rsp_occupancy);
         if (start && !busy)
            sb.log_request(lffl_pkg::mode_type'(req_mode), req_write_value);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("linked_fifo_with_free_list_core test failed");
         $finish;
      end
   end

   function automatic logic [lffl_pkg::VALUE_W-1:0] random_word();
      logic [lffl_pkg::VALUE_W-1:0] w;
      case ($urandom_range(7))
         0:       w = '0;
         1:       w = '1;
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic drive_op(input lffl_pkg::mode_type op,
                           input logic [lffl_pkg::VALUE_W-1:0] value,
                           input bit no_gaps);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         start           <= 1'b0;
         req_mode        <= 1'($urandom_range(1));
         req_write_value <= {$urandom, $urandom};
         @(negedge clock);
      end
      start           <= 1'b1;
      req_mode        <= op;
      req_write_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      lffl_pkg::mode_type op;
      int                 write_pct;
      bit                 no_gaps;

      reset           = 1'b1;
      start           = 1'b0;
      req_mode        = lffl_pkg::MODE_WRITE;
      req_write_value = '0;
      write_pct       = 50;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: read when empty, extreme words, drain, then empty again
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);
      drive_op(lffl_pkg::MODE_WRITE, '0, 1'b0);
      drive_op(lffl_pkg::MODE_WRITE, '1, 1'b0);
      drive_op(lffl_pkg::MODE_WRITE, {32{2'b01}}, 1'b0);
      drive_op(lffl_pkg::MODE_WRITE, {32{2'b10}}, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '1, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);
      drive_op(lffl_pkg::MODE_WRITE, 64'h8000_0000_0000_0001, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);
      drive_op(lffl_pkg::MODE_READ,  '0, 1'b0);

      // random: bursts biased toward filling or draining, or balanced, so both the
      // full and the empty refusals come up often
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0:       write_pct = 15;
               1:       write_pct = 50;
               default: write_pct = 85;
            endcase
         end
         op      = ($urandom_range(99) < write_pct) ? lffl_pkg::MODE_WRITE
                                                    : lffl_pkg::MODE_READ;
         no_gaps = (k >= 500 && k < 800);
         drive_op(op, random_word(), no_gaps);
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d writes, %0d reads, %0d refused writes (full),",
               sb.writes_done, sb.reads_done, sb.writes_refused);
      $display("%0d refused reads (empty); mismatches: %0d",
               sb.reads_refused, sb.errors);
      if (sb.errors == 0)
         $display("linked_fifo_with_free_list_core test passed");
      else
         $display("linked_fifo_with_free_list_core test failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/lffl_pkg.sv
src/linked_fifo_with_free_list_core.sv
tb/linked_fifo_with_free_list_core_tb.sv
